[hdl/tlv_datapoint_parser_assert.svh]
// assertion macros shared by the tlv datapoint parser modules
// expects clk_i and rst_ni in the scope of each use
`ifndef TLV_DATAPOINT_PARSER_ASSERT_SVH
`define TLV_DATAPOINT_PARSER_ASSERT_SVH

// same-cycle implication
`define TLVDP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlvdp assertion failed");

// next-cycle implication
`define TLVDP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlvdp assertion failed");

`endif

[hdl/tlvdp_pkg.sv]
// types and codes for the tlv datapoint parser
// no dependencies
`default_nettype none

package tlvdp_pkg;

  typedef enum logic [1:0] {
    KIND_VALUE_BYTE = 2'd0,
    KIND_SUMMARY    = 2'd1,
    KIND_BAD_TYPE   = 2'd2,
    KIND_OVERRUN    = 2'd3
  } kind_e;

  localparam logic [7:0] TYPE_RAW    = 8'd0;
  localparam logic [7:0] TYPE_BOOL   = 8'd1;
  localparam logic [7:0] TYPE_VALUE  = 8'd2;
  localparam logic [7:0] TYPE_STRING = 8'd3;
  localparam logic [7:0] TYPE_ENUM   = 8'd4;
  localparam logic [7:0] TYPE_BITMAP = 8'd5;

  localparam int unsigned IntBytes = 4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] msg_length;
    logic [7:0]  skip_count;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         dp_id;
    logic [7:0]         dp_type;
    logic [7:0]         value_byte;
    logic signed [31:0] dec_value;
    logic               dec_flag;
    logic [7:0]         value_length;
    logic               record_end;
  } out_t;

endpackage

`default_nettype wire

[hdl/tlvdp_parse.sv]
// record parser state and per-byte result logic
// depends on tlvdp_pkg and tlv_datapoint_parser_assert.svh
`default_nettype none
`include "tlv_datapoint_parser_assert.svh"

module tlvdp_parse #(
  parameter int unsigned MAX_MESSAGE_BYTES = 65535
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_fire_i,
  input  wire tlvdp_pkg::in_t in_data_i,
  output logic                res_valid_o,
  output tlvdp_pkg::out_t     res_o
);

  localparam int unsigned PosMax = (MAX_MESSAGE_BYTES > 255) ? MAX_MESSAGE_BYTES : 255;
  localparam int unsigned PW     = $clog2(PosMax + 1);
  localparam int unsigned LW     = $clog2(MAX_MESSAGE_BYTES + 1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SKIP  = 3'd1,
    PH_ID    = 3'd2,
    PH_TYPE  = 3'd3,
    PH_LEN   = 3'd4,
    PH_VALUE = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d, phase_c;
  logic [PW-1:0] pos_q, pos_d, pos_c;
  logic [LW-1:0] len_q, len_d, len_c;
  logic [7:0]  id_q, id_d, id_c;
  logic [7:0]  type_q, type_d, type_c;
  logic [7:0]  rlen_q, rlen_d, rlen_c;
  logic [7:0]  cnt_q, cnt_d, cnt_c;
  logic [31:0] acc_q, acc_d, acc_c;
  logic [7:0]  fvb_q, fvb_d, fvb_c;
  logic [7:0]  skip_q, skip_d, skip_c;

  logic [15:0]   len_sat;
  logic [PW:0]   pos_ext;
  logic [PW:0]   len_ext;
  logic [7:0]    b;
  logic          last;
  logic          do_inc;
  logic          emit;
  logic          emit_sum;
  tlvdp_pkg::kind_e kind;
  logic [7:0]    vbyte;
  logic [31:0]   sum_int;
  logic          sum_bool;

  assign b       = in_data_i.data_byte;
  assign len_sat = (in_data_i.msg_length > 16'(MAX_MESSAGE_BYTES)) ?
                   16'(MAX_MESSAGE_BYTES) : in_data_i.msg_length;

  // a first byte restarts the message before the byte itself is parsed
  always_comb begin
    if (in_data_i.first_byte) begin
      phase_c = (in_data_i.skip_count != 8'd0) ? PH_SKIP : PH_ID;
      pos_c   = '0;
      len_c   = LW'(len_sat);
      id_c    = 8'd0;
      type_c  = 8'd0;
      rlen_c  = 8'd0;
      cnt_c   = 8'd0;
      acc_c   = 32'd0;
      fvb_c   = 8'd0;
      skip_c  = in_data_i.skip_count;
    end else begin
      phase_c = phase_q;
      pos_c   = pos_q;
      len_c   = len_q;
      id_c    = id_q;
      type_c  = type_q;
      rlen_c  = rlen_q;
      cnt_c   = cnt_q;
      acc_c   = acc_q;
      fvb_c   = fvb_q;
      skip_c  = skip_q;
    end
  end

  assign pos_ext = {1'b0, pos_c};
  assign len_ext = (PW+1)'(len_c);

  always_comb begin
    phase_d  = phase_c;
    id_d     = id_c;
    type_d   = type_c;
    rlen_d   = rlen_c;
    cnt_d    = cnt_c;
    acc_d    = acc_c;
    fvb_d    = fvb_c;
    skip_d   = skip_c;
    last     = 1'b0;
    do_inc   = 1'b0;
    emit     = 1'b0;
    emit_sum = 1'b0;
    kind     = tlvdp_pkg::KIND_VALUE_BYTE;
    vbyte    = 8'd0;
    unique case (phase_c)
      PH_SKIP: begin
        do_inc = 1'b1;
        skip_d = (skip_c != 8'd0) ? skip_c - 8'd1 : skip_c;
        if (skip_d == 8'd0) begin
          phase_d = PH_ID;
        end
      end
      PH_ID: begin
        if (pos_ext + (PW+1)'(tlvdp_pkg::IntBytes) > len_ext) begin
          phase_d = PH_IDLE;
        end else begin
          do_inc  = 1'b1;
          id_d    = b;
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        do_inc  = 1'b1;
        type_d  = b;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        rlen_d = b;
        cnt_d  = 8'd0;
        acc_d  = 32'd0;
        fvb_d  = 8'd0;
        if (type_c > tlvdp_pkg::TYPE_BITMAP) begin
          emit    = 1'b1;
          kind    = tlvdp_pkg::KIND_BAD_TYPE;
          phase_d = PH_IDLE;
        end else if (pos_ext + (PW+1)'(1) + (PW+1)'(b) > len_ext) begin
          emit    = 1'b1;
          kind    = tlvdp_pkg::KIND_OVERRUN;
          phase_d = PH_IDLE;
        end else if (b == 8'd0) begin
          do_inc   = 1'b1;
          emit     = 1'b1;
          emit_sum = 1'b1;
          kind     = tlvdp_pkg::KIND_SUMMARY;
          phase_d  = PH_ID;
        end else begin
          do_inc  = 1'b1;
          phase_d = PH_VALUE;
        end
      end
      PH_VALUE: begin
        do_inc = 1'b1;
        fvb_d  = (cnt_c == 8'd0) ? b : fvb_c;
        acc_d  = (cnt_c < 8'(tlvdp_pkg::IntBytes)) ? {acc_c[23:0], b} : acc_c;
        cnt_d  = cnt_c + 8'd1;
        last   = (cnt_d == rlen_c);
        if (type_c == tlvdp_pkg::TYPE_RAW || type_c == tlvdp_pkg::TYPE_STRING ||
            type_c == tlvdp_pkg::TYPE_BITMAP) begin
          emit  = 1'b1;
          kind  = tlvdp_pkg::KIND_VALUE_BYTE;
          vbyte = b;
        end else if (last) begin
          emit     = 1'b1;
          emit_sum = 1'b1;
          kind     = tlvdp_pkg::KIND_SUMMARY;
        end
        if (last) begin
          phase_d = PH_ID;
        end
      end
      default: begin
        phase_d = phase_c;
      end
    endcase
  end

  assign pos_d = do_inc ? pos_c + PW'(1) : pos_c;
  assign len_d = len_c;

  // summary from the values left after this byte
  always_comb begin
    sum_int  = 32'd0;
    sum_bool = 1'b0;
    if (type_c == tlvdp_pkg::TYPE_BOOL) begin
      sum_bool = (rlen_d != 8'd0) && (fvb_d != 8'd0);
      sum_int  = {31'd0, sum_bool};
    end else if (type_c == tlvdp_pkg::TYPE_VALUE || type_c == tlvdp_pkg::TYPE_ENUM) begin
      sum_int = acc_d;
      if (type_c == tlvdp_pkg::TYPE_VALUE && fvb_d[7]) begin
        case (rlen_d)
          8'd1:    sum_int = acc_d | 32'hFFFF_FF00;
          8'd2:    sum_int = acc_d | 32'hFFFF_0000;
          8'd3:    sum_int = acc_d | 32'hFF00_0000;
          default: sum_int = acc_d;
        endcase
      end
      sum_bool = (sum_int != 32'd0);
    end
  end

  assign res_valid_o         = in_fire_i && emit;
  assign res_o.kind          = kind;
  assign res_o.dp_id         = id_d;
  assign res_o.dp_type       = type_d;
  assign res_o.value_byte    = vbyte;
  assign res_o.dec_value     = emit_sum ? sum_int : 32'd0;
  assign res_o.dec_flag      = emit_sum ? sum_bool : 1'b0;
  assign res_o.value_length  = rlen_d;
  assign res_o.record_end    = emit_sum || (kind == tlvdp_pkg::KIND_VALUE_BYTE && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      len_q   <= '0;
      id_q    <= 8'd0;
      type_q  <= 8'd0;
      rlen_q  <= 8'd0;
      cnt_q   <= 8'd0;
      acc_q   <= 32'd0;
      fvb_q   <= 8'd0;
      skip_q  <= 8'd0;
    end else if (in_fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      id_q    <= id_d;
      type_q  <= type_d;
      rlen_q  <= rlen_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      fvb_q   <= fvb_d;
      skip_q  <= skip_d;
    end
  end

  // errors end the message
  `TLVDP_ASSERT_NEXT(a_err_ends_msg,
    res_valid_o && (res_o.kind == tlvdp_pkg::KIND_BAD_TYPE ||
    res_o.kind == tlvdp_pkg::KIND_OVERRUN), phase_q == PH_IDLE)
  // errors never close a record
  `TLVDP_ASSERT_NOW(a_err_no_end,
    res_valid_o && (res_o.kind == tlvdp_pkg::KIND_BAD_TYPE ||
    res_o.kind == tlvdp_pkg::KIND_OVERRUN), !res_o.record_end)
  // value bytes only come while inside a record value
  `TLVDP_ASSERT_NOW(a_vbyte_in_value,
    res_valid_o && res_o.kind == tlvdp_pkg::KIND_VALUE_BYTE, phase_c == PH_VALUE)

endmodule

`default_nettype wire

[hdl/tlvdp_out_buf.sv]
// result register with a one-beat skid stage
// depends on tlvdp_pkg and tlv_datapoint_parser_assert.svh
`default_nettype none
`include "tlv_datapoint_parser_assert.svh"

module tlvdp_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            res_valid_i,
  input  wire tlvdp_pkg::out_t res_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output tlvdp_pkg::out_t      out_data_o
);

  logic            out_valid_q;
  logic            skid_valid_q;
  tlvdp_pkg::out_t out_q;
  tlvdp_pkg::out_t skid_q;
  logic            out_fire;

  assign out_fire = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid_i) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_valid_i) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the skid stage only fills behind a waiting result
  `TLVDP_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
  // a taken result drains the skid stage
  `TLVDP_ASSERT_NEXT(a_skid_drains, skid_valid_q && !out_stall_i, !skid_valid_q && out_valid_q)
  // no beat arrives while the skid stage is full
  `TLVDP_ASSERT_NOW(a_no_beat_when_full, skid_valid_q, !res_valid_i)

endmodule

`default_nettype wire

[hdl/tlv_datapoint_parser.sv]
// Streaming id/type/length/value record parser, one message byte per input beat.
// Takes one byte every clock cycle while in_stall_o is low; each byte passes
// through the parser state logic in the cycle it is accepted and its result,
// if any, is registered. A result register plus a one-beat skid stage let input
// continue while a result waits; in_stall_o rises only when both hold a result.
// Depends on tlvdp_pkg, tlvdp_parse and tlvdp_out_buf.
`default_nettype none

module tlv_datapoint_parser #(
  parameter int unsigned MAX_MESSAGE_BYTES = 65535
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire tlvdp_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output tlvdp_pkg::out_t      out_data_o
);

  logic            in_fire;
  logic            full;
  logic            res_valid;
  tlvdp_pkg::out_t res;

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;

  tlvdp_parse #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  tlvdp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
